// File: rtl/core/point_pair_bearing_and_distance_core_defines.svh
// assertion macros for the point pair bearing and distance core
`ifndef POINT_PAIR_BEARING_AND_DISTANCE_CORE_DEFINES_SVH
`define POINT_PAIR_BEARING_AND_DISTANCE_CORE_DEFINES_SVH

// property checked at each rising edge, dropped while reset is low
`define PPBD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// property checked at each rising edge, reset included
`define PPBD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// File: rtl/core/ppbd_pkg.sv
// shared types, constants and tables of the point pair bearing and distance core
package ppbd_pkg;

  // operand and fixed point formats
  localparam int unsigned CoordBits   = 16;
  localparam int unsigned FracBits    = 8;
  localparam int unsigned DiffBits    = CoordBits + 1;
  localparam int unsigned MagBits     = CoordBits;
  localparam int unsigned SqBits      = 2 * CoordBits + 1;
  localparam int unsigned RadBits     = SqBits + 2 * FracBits + 2;
  localparam int unsigned RootBits    = (RadBits + 1) / 2;
  localparam int unsigned RadPadBits  = 2 * RootBits;
  localparam int unsigned RemBits     = RootBits + 3;

  // result formats
  localparam int unsigned LengthBits  = 25;
  localparam int unsigned BearingBits = 17;
  localparam int unsigned RegionBits  = 3;

  // cordic datapath
  localparam int unsigned CordicBits  = 64;
  localparam int unsigned AngleBits   = 32;
  localparam int unsigned AngleFrac   = 24;
  localparam int unsigned CordicSteps = 28;
  localparam int unsigned PreShift    = 60 - CoordBits;
  localparam int unsigned AngleShift  = AngleFrac - FracBits;

  // input register, cordic stages, two output stages
  localparam int unsigned Latency     = 1 + CordicSteps + 2;

  localparam logic [BearingBits-1:0] FullTurn    = BearingBits'(360 << FracBits);
  localparam logic [BearingBits-1:0] HalfTurn    = BearingBits'(180 << FracBits);
  localparam logic [BearingBits-1:0] QuarterTurn = BearingBits'(90 << FracBits);
  localparam logic [BearingBits-1:0] ThreeQTurn  = BearingBits'(270 << FracBits);

  typedef enum logic [RegionBits-1:0] {
    REGION_NE    = 3'd0,
    REGION_SE    = 3'd1,
    REGION_SW    = 3'd2,
    REGION_NW    = 3'd3,
    REGION_UP    = 3'd4,
    REGION_DOWN  = 3'd5,
    REGION_SAME  = 3'd6,
    REGION_HORIZ = 3'd7
  } region_e;

  typedef struct packed {
    logic               valid;
    region_e            region;
    logic               west;
    logic [MagBits-1:0] p;
    logic [MagBits-1:0] q;
  } cordic_in_t;

  typedef struct packed {
    logic                        valid;
    region_e                     region;
    logic                        west;
    logic signed [AngleBits-1:0] z;
  } cordic_out_t;

  typedef struct packed {
    logic              valid;
    logic [SqBits-1:0] sq;
  } sqrt_in_t;

  typedef struct packed {
    logic                valid;
    logic [RootBits-1:0] root;
  } sqrt_out_t;

  // atan(2^-i) in units of 2^-24 degree
  function automatic logic [AngleBits-1:0] atan_step(int unsigned i);
    logic [AngleBits-1:0] t;
    case (i)
      0:       t = 32'd754974720;
      1:       t = 32'd445687602;
      2:       t = 32'd235489089;
      3:       t = 32'd119537938;
      4:       t = 32'd60000934;
      5:       t = 32'd30029717;
      6:       t = 32'd15018523;
      7:       t = 32'd7509720;
      8:       t = 32'd3754917;
      9:       t = 32'd1877466;
      10:      t = 32'd938734;
      11:      t = 32'd469367;
      12:      t = 32'd234684;
      13:      t = 32'd117342;
      14:      t = 32'd58671;
      15:      t = 32'd29335;
      16:      t = 32'd14668;
      17:      t = 32'd7334;
      18:      t = 32'd3667;
      19:      t = 32'd1833;
      20:      t = 32'd917;
      21:      t = 32'd458;
      22:      t = 32'd229;
      23:      t = 32'd115;
      24:      t = 32'd57;
      25:      t = 32'd29;
      26:      t = 32'd14;
      27:      t = 32'd7;
      default: t = '0;
    endcase
    return t;
  endfunction

  // bearing at the start of each diagonal quadrant
  function automatic logic [BearingBits-1:0] quadrant_base(region_e r);
    logic [BearingBits-1:0] b;
    unique case (r)
      REGION_SE: b = QuarterTurn;
      REGION_SW: b = HalfTurn;
      REGION_NW: b = ThreeQTurn;
      default:   b = '0;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/core/ppbd_front.sv
// input register, region decode and squared distance stages
module ppbd_front (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   accept_i,
  input  logic signed [ppbd_pkg::CoordBits-1:0]  first_x_i,
  input  logic signed [ppbd_pkg::CoordBits-1:0]  first_y_i,
  input  logic signed [ppbd_pkg::CoordBits-1:0]  second_x_i,
  input  logic signed [ppbd_pkg::CoordBits-1:0]  second_y_i,
  output ppbd_pkg::cordic_in_t                   cordic_o,
  output ppbd_pkg::sqrt_in_t                     sqrt_o
);

  localparam int unsigned DW = ppbd_pkg::DiffBits;
  localparam int unsigned MW = ppbd_pkg::MagBits;
  localparam int unsigned SW = ppbd_pkg::SqBits;

  logic signed [DW-1:0] dx, dy;
  logic [DW-1:0]        abs_x, abs_y;
  logic [MW-1:0]        ax, ay;
  ppbd_pkg::region_e    region_d;

  // stage a
  logic                 a_valid_q;
  ppbd_pkg::region_e    a_region_q;
  logic                 a_west_q;
  logic [MW-1:0]        a_ax_q, a_ay_q, a_p_q, a_q_q;
  logic [MW-1:0]        p_d, q_d;
  // stage b, stage c
  logic                 b_valid_q, c_valid_q;
  logic [2*MW-1:0]      b_sqx_q, b_sqy_q;
  logic [SW-1:0]        c_sq_q;

  assign dx    = DW'(second_x_i) - DW'(first_x_i);
  assign dy    = DW'(second_y_i) - DW'(first_y_i);
  assign abs_x = dx[DW-1] ? -dx : dx;
  assign abs_y = dy[DW-1] ? -dy : dy;
  assign ax    = abs_x[MW-1:0];
  assign ay    = abs_y[MW-1:0];

  always_comb begin
    if (dx == '0 && dy == '0) begin
      region_d = ppbd_pkg::REGION_SAME;
    end else if (dx == '0) begin
      region_d = dy[DW-1] ? ppbd_pkg::REGION_DOWN : ppbd_pkg::REGION_UP;
    end else if (dy == '0) begin
      region_d = ppbd_pkg::REGION_HORIZ;
    end else if (!dx[DW-1] && !dy[DW-1]) begin
      region_d = ppbd_pkg::REGION_NE;
    end else if (!dx[DW-1]) begin
      region_d = ppbd_pkg::REGION_SE;
    end else if (dy[DW-1]) begin
      region_d = ppbd_pkg::REGION_SW;
    end else begin
      region_d = ppbd_pkg::REGION_NW;
    end
  end

  // angle within the quadrant is atan(p/q)
  always_comb begin
    case (region_d) inside
      ppbd_pkg::REGION_SE, ppbd_pkg::REGION_NW: begin
        p_d = ay;
        q_d = ax;
      end
      default: begin
        p_d = ax;
        q_d = ay;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      a_valid_q <= accept_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      a_region_q <= region_d;
      a_west_q   <= dx[DW-1];
      a_ax_q     <= ax;
      a_ay_q     <= ay;
      a_p_q      <= p_d;
      a_q_q      <= q_d;
    end
    if (a_valid_q) begin
      b_sqx_q <= a_ax_q * a_ax_q;
      b_sqy_q <= a_ay_q * a_ay_q;
    end
    if (b_valid_q) begin
      c_sq_q <= SW'(b_sqx_q) + SW'(b_sqy_q);
    end
  end

  assign cordic_o.valid  = a_valid_q;
  assign cordic_o.region = a_region_q;
  assign cordic_o.west   = a_west_q;
  assign cordic_o.p      = a_p_q;
  assign cordic_o.q      = a_q_q;

  assign sqrt_o.valid = c_valid_q;
  assign sqrt_o.sq    = c_sq_q;

endmodule

// File: rtl/core/ppbd_isqrt.sv
// pipelined integer square root, one root bit per stage
module ppbd_isqrt (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ppbd_pkg::sqrt_in_t  sqrt_i,
  output ppbd_pkg::sqrt_out_t sqrt_o
);

  localparam int unsigned NB = ppbd_pkg::RootBits;
  localparam int unsigned PW = ppbd_pkg::RadPadBits;
  localparam int unsigned EW = ppbd_pkg::RemBits;
  localparam int unsigned LowZeros = 2 * ppbd_pkg::FracBits + 2;

  logic          valid_q [NB];
  logic [EW-1:0] rem_q   [NB];
  logic [NB-1:0] root_q  [NB];
  logic [PW-1:0] rad_q   [NB];
  logic [PW-1:0] rad_first;

  // radicand is the squared distance scaled by 2^(2f+2)
  assign rad_first = PW'({sqrt_i.sq, {LowZeros{1'b0}}});

  for (genvar k = 0; k < NB; k++) begin : g_stage
    localparam int unsigned J = NB - 1 - k;
    logic          v_in;
    logic [EW-1:0] rem_in, rem_sh, trial, rem_d;
    logic [NB-1:0] root_in, root_d;
    logic [PW-1:0] rad_in;
    logic          fits;

    if (k == 0) begin : g_first
      assign v_in    = sqrt_i.valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_first;
    end else begin : g_next
      assign v_in    = valid_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
    end

    assign rem_sh = {rem_in[EW-3:0], rad_in[2*J+1 -: 2]};
    assign trial  = EW'({root_in, 2'b01});
    assign fits   = rem_sh >= trial;
    assign rem_d  = fits ? rem_sh - trial : rem_sh;
    assign root_d = {root_in[NB-2:0], fits};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (v_in) begin
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        rad_q[k]  <= rad_in;
      end
    end
  end

  assign sqrt_o.valid = valid_q[NB-1];
  assign sqrt_o.root  = root_q[NB-1];

endmodule

// File: rtl/core/ppbd_cordic.sv
// unrolled vectoring cordic, one rotation per stage
module ppbd_cordic (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ppbd_pkg::cordic_in_t  cordic_i,
  output ppbd_pkg::cordic_out_t cordic_o
);

  localparam int unsigned NS = ppbd_pkg::CordicSteps;
  localparam int unsigned CW = ppbd_pkg::CordicBits;
  localparam int unsigned ZW = ppbd_pkg::AngleBits;

  logic                     valid_q  [NS];
  ppbd_pkg::region_e        region_q [NS];
  logic                     west_q   [NS];
  logic signed [CW-1:0]     x_q      [NS];
  logic signed [CW-1:0]     y_q      [NS];
  logic signed [ZW-1:0]     z_q      [NS];
  logic signed [CW-1:0]     x_first, y_first;

  assign x_first = CW'(cordic_i.q) << ppbd_pkg::PreShift;
  assign y_first = CW'(cordic_i.p) << ppbd_pkg::PreShift;

  for (genvar i = 0; i < NS; i++) begin : g_stage
    logic                 v_in, w_in;
    ppbd_pkg::region_e    r_in;
    logic signed [CW-1:0] x_in, y_in, xs, ys, x_d, y_d;
    logic signed [ZW-1:0] z_in, z_d, t;

    if (i == 0) begin : g_first
      assign v_in = cordic_i.valid;
      assign r_in = cordic_i.region;
      assign w_in = cordic_i.west;
      assign x_in = x_first;
      assign y_in = y_first;
      assign z_in = '0;
    end else begin : g_next
      assign v_in = valid_q[i-1];
      assign r_in = region_q[i-1];
      assign w_in = west_q[i-1];
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
      assign z_in = z_q[i-1];
    end

    // arithmetic shifts floor toward minus infinity
    assign xs = x_in >>> i;
    assign ys = y_in >>> i;
    assign t  = signed'(ppbd_pkg::atan_step(i));

    always_comb begin
      if (!y_in[CW-1]) begin
        x_d = x_in + ys;
        y_d = y_in - xs;
        z_d = z_in + t;
      end else begin
        x_d = x_in - ys;
        y_d = y_in + xs;
        z_d = z_in - t;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else begin
        valid_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (v_in) begin
        region_q[i] <= r_in;
        west_q[i]   <= w_in;
        x_q[i]      <= x_d;
        y_q[i]      <= y_d;
        z_q[i]      <= z_d;
      end
    end
  end

  assign cordic_o.valid  = valid_q[NS-1];
  assign cordic_o.region = region_q[NS-1];
  assign cordic_o.west   = west_q[NS-1];
  assign cordic_o.z      = z_q[NS-1];

endmodule

// File: rtl/core/ppbd_post.sv
// angle rounding, quadrant offset, wrap and result register
module ppbd_post (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  ppbd_pkg::cordic_out_t                cordic_i,
  input  ppbd_pkg::sqrt_out_t                  sqrt_i,
  output logic                                 valid_o,
  output logic [ppbd_pkg::LengthBits-1:0]      length_o,
  output logic [ppbd_pkg::BearingBits-1:0]     bearing_out_o,
  output logic [ppbd_pkg::BearingBits-1:0]     bearing_back_o,
  output ppbd_pkg::region_e                    region_o
);

  localparam int unsigned ZW = ppbd_pkg::AngleBits;
  localparam int unsigned BW = ppbd_pkg::BearingBits;
  localparam int unsigned LW = ppbd_pkg::LengthBits;
  localparam int unsigned NB = ppbd_pkg::RootBits;
  localparam int unsigned SH = ppbd_pkg::AngleShift;

  logic [ZW-1:0] z_clamp, z_round;
  logic [BW-1:0] atan_d, raw_d;
  logic [NB:0]   len_sum;

  // stage o1
  logic              o1_valid_q;
  ppbd_pkg::region_e o1_region_q;
  logic              o1_west_q;
  logic [BW-1:0]     o1_raw_q;
  logic [LW-1:0]     o1_len_q;

  // stage o2
  logic              o2_valid_q;
  ppbd_pkg::region_e o2_region_q;
  logic [BW-1:0]     o2_bearing_q, o2_back_q;
  logic [LW-1:0]     o2_len_q;

  logic [BW-1:0]     bearing_d, back_d, wrap_fwd;
  logic [BW:0]       back_sum, wrap_back;
  logic [LW-1:0]     len_d;

  assign z_clamp = cordic_i.z[ZW-1] ? '0 : cordic_i.z;
  assign z_round = z_clamp + ZW'(1 << (SH - 1));
  // rounded angle is at most a quarter turn, well inside the bearing width
  assign atan_d  = BW'(z_round[ZW-1:SH]);
  assign raw_d   = ppbd_pkg::quadrant_base(cordic_i.region) + atan_d;

  // round half up: root carries one extra fraction bit
  assign len_sum = (NB + 1)'(sqrt_i.root) + (NB + 1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o1_valid_q <= 1'b0;
      o2_valid_q <= 1'b0;
    end else begin
      o1_valid_q <= cordic_i.valid;
      o2_valid_q <= o1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cordic_i.valid) begin
      o1_region_q <= cordic_i.region;
      o1_west_q   <= cordic_i.west;
      o1_raw_q    <= raw_d;
    end
    if (sqrt_i.valid) begin
      o1_len_q <= LW'(len_sum[NB:1]);
    end
  end

  // raw bearing stays below two turns, so one subtract wraps it
  assign wrap_fwd  = (o1_raw_q >= ppbd_pkg::FullTurn) ? o1_raw_q - ppbd_pkg::FullTurn
                                                      : o1_raw_q;
  assign back_sum  = (BW + 1)'(o1_raw_q) + (BW + 1)'(ppbd_pkg::HalfTurn);
  assign wrap_back = (back_sum >= (BW + 1)'(ppbd_pkg::FullTurn))
                     ? back_sum - (BW + 1)'(ppbd_pkg::FullTurn) : back_sum;

  always_comb begin
    len_d = o1_len_q;
    case (o1_region_q) inside
      ppbd_pkg::REGION_UP: begin
        bearing_d = '0;
        back_d    = ppbd_pkg::HalfTurn;
      end
      ppbd_pkg::REGION_DOWN: begin
        bearing_d = ppbd_pkg::HalfTurn;
        back_d    = '0;
      end
      ppbd_pkg::REGION_HORIZ: begin
        bearing_d = o1_west_q ? ppbd_pkg::ThreeQTurn : ppbd_pkg::QuarterTurn;
        back_d    = o1_west_q ? ppbd_pkg::QuarterTurn : ppbd_pkg::ThreeQTurn;
      end
      ppbd_pkg::REGION_SAME: begin
        bearing_d = '0;
        back_d    = '0;
        len_d     = '0;
      end
      default: begin
        bearing_d = wrap_fwd;
        back_d    = BW'(wrap_back);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (o1_valid_q) begin
      o2_region_q  <= o1_region_q;
      o2_bearing_q <= bearing_d;
      o2_back_q    <= back_d;
      o2_len_q     <= len_d;
    end
  end

  assign valid_o        = o2_valid_q;
  assign length_o       = o2_len_q;
  assign bearing_out_o  = o2_bearing_q;
  assign bearing_back_o = o2_back_q;
  assign region_o       = o2_region_q;

endmodule

// File: rtl/core/point_pair_bearing_and_distance_core.sv
// top level of the point pair bearing and distance core
//
// usage
//   a point pair is transferred in at a rising edge where start is high and
//   busy is low. busy is held low: the core is fully pipelined and takes a
//   new pair in every cycle, so start may stay high for any number of cycles.
//   each pair yields one result: length_o, bearing_out_o, bearing_back_o and
//   region_o, shown for exactly one cycle while result_valid_o is high, and
//   transferred out at the edge that ends that cycle.
// pipeline and throughput
//   a pair passes one input register, 28 cordic rotation stages, then two
//   output stages. the square root runs beside the cordic (a squaring stage
//   and a sum stage ahead of 26 root-bit stages) and ends in the same cycle.
//   throughput is one pair per cycle, results in order.
// reset
//   rst_ni clears all stage valid bits at once; pairs in flight are dropped
//   and no strobe is raised until new pairs come through.
// output side
//   the receiver cannot stall, so nothing is held back; results stream out
//   with the same spacing the pairs had on the way in.
module point_pair_bearing_and_distance_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [ppbd_pkg::CoordBits-1:0]  first_x_i,
  input  logic signed [ppbd_pkg::CoordBits-1:0]  first_y_i,
  input  logic signed [ppbd_pkg::CoordBits-1:0]  second_x_i,
  input  logic signed [ppbd_pkg::CoordBits-1:0]  second_y_i,
  output logic                                   result_valid_o,
  output logic [ppbd_pkg::LengthBits-1:0]        length_o,
  output logic [ppbd_pkg::BearingBits-1:0]       bearing_out_o,
  output logic [ppbd_pkg::BearingBits-1:0]       bearing_back_o,
  output logic [ppbd_pkg::RegionBits-1:0]        region_o
);

  logic                  accept;
  ppbd_pkg::cordic_in_t  cordic_in;
  ppbd_pkg::cordic_out_t cordic_out;
  ppbd_pkg::sqrt_in_t    sqrt_in;
  ppbd_pkg::sqrt_out_t   sqrt_out;
  ppbd_pkg::region_e     region;

  // every stage advances each cycle, so the input side never has to wait
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // differences, region decode, squares and their sum
  ppbd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .first_x_i  (first_x_i),
    .first_y_i  (first_y_i),
    .second_x_i (second_x_i),
    .second_y_i (second_y_i),
    .cordic_o   (cordic_in),
    .sqrt_o     (sqrt_in)
  );

  // in-quadrant angle atan(p/q), starts in the cycle after the transfer
  ppbd_cordic u_cordic (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cordic_i (cordic_in),
    .cordic_o (cordic_out)
  );

  // distance, fed through the input, squaring and sum registers, lines up with the cordic
  ppbd_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sqrt_i (sqrt_in),
    .sqrt_o (sqrt_out)
  );

  // rounding, quadrant offset, axis and same-point cases, wrap into one turn
  ppbd_post u_post (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cordic_i       (cordic_out),
    .sqrt_i         (sqrt_out),
    .valid_o        (result_valid_o),
    .length_o       (length_o),
    .bearing_out_o  (bearing_out_o),
    .bearing_back_o (bearing_back_o),
    .region_o       (region)
  );

  assign region_o = region;

endmodule

// File: rtl/core/ppbd_checker.sv
// port level checks of the point pair bearing and distance core
`include "point_pair_bearing_and_distance_core_defines.svh"

module ppbd_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                start,
  input logic                                busy,
  input logic                                result_valid_o,
  input logic [ppbd_pkg::LengthBits-1:0]     length_o,
  input logic [ppbd_pkg::BearingBits-1:0]    bearing_out_o,
  input logic [ppbd_pkg::BearingBits-1:0]    bearing_back_o,
  input logic [ppbd_pkg::RegionBits-1:0]     region_o
);

  localparam int unsigned Lat = ppbd_pkg::Latency;
  localparam logic [ppbd_pkg::BearingBits-1:0] Half = ppbd_pkg::HalfTurn;
  localparam logic [ppbd_pkg::RegionBits-1:0] SameCode = ppbd_pkg::REGION_SAME;
  localparam logic [ppbd_pkg::RegionBits-1:0] UpCode = ppbd_pkg::REGION_UP;

  // no strobe in the cycle after reset is seen low
  `PPBD_ASSERT_ALWAYS(a_quiet_in_reset, clk_i, !rst_ni |=> !result_valid_o, "strobe during reset")

  // every transferred pair comes out after the fixed latency
  `PPBD_ASSERT(a_latency, clk_i, rst_ni, (start && !busy) |-> ##Lat result_valid_o, "result missing")

  // reverse bearing is the bearing turned half a circle, except for coincident points
  `PPBD_ASSERT(a_back_half_turn, clk_i, rst_ni, (result_valid_o && region_o != SameCode) |-> ((bearing_out_o >= Half) ? (bearing_back_o == bearing_out_o - Half) : (bearing_back_o == bearing_out_o + Half)), "reverse bearing off")

  // coincident points give all zero
  `PPBD_ASSERT(a_same_point_zero, clk_i, rst_ni, (result_valid_o && region_o == SameCode) |-> (length_o == '0 && bearing_out_o == '0 && bearing_back_o == '0), "same point not zero")

  // straight up points north
  `PPBD_ASSERT(a_up_north, clk_i, rst_ni, (result_valid_o && region_o == UpCode) |-> (bearing_out_o == '0 && length_o != '0), "up bearing off")

endmodule

bind point_pair_bearing_and_distance_core ppbd_checker u_ppbd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .length_o       (length_o),
  .bearing_out_o  (bearing_out_o),
  .bearing_back_o (bearing_back_o),
  .region_o       (region_o)
);

// File: tb/tb_point_pair_bearing_and_distance_core.sv
// self-checking testbench for the point pair bearing and distance core
`timescale 1ns / 1ps

module tb_point_pair_bearing_and_distance_core;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned RandomPairs = 500;

  localparam int unsigned CoordW   = ppbd_pkg::CoordBits;
  localparam int unsigned LengthW  = ppbd_pkg::LengthBits;
  localparam int unsigned BearingW = ppbd_pkg::BearingBits;
  localparam int unsigned RegionW  = ppbd_pkg::RegionBits;

  // atan(2^-i) in 2^-24 degree
  localparam longint ArctanLut [0:27] = '{
    754974720, 445687602, 235489089, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
    58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
  };

  // predicts one result per transferred pair and checks results in order
  class bearing_scoreboard;
    typedef struct {
      logic signed [CoordW-1:0] fx, fy, sx, sy;
      logic [LengthW-1:0]       length;
      logic [BearingW-1:0]      bearing_out;
      logic [BearingW-1:0]      bearing_back;
      ppbd_pkg::region_e        area;
    } bearing_rec_t;

    bearing_rec_t awaited[$];
    int unsigned  bad_count;

    function new();
      bad_count = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned rem, root, probe;
      rem   = n;
      root  = 0;
      probe = 64'h4000_0000_0000_0000;
      while (probe > rem) probe >>= 2;
      while (probe != 0) begin
        if (rem >= root + probe) begin
          rem  -= root + probe;
          root  = (root >> 1) + probe;
        end else begin
          root >>= 1;
        end
        probe >>= 2;
      end
      return root;
    endfunction

    // vectoring rotations, angle of (q, p) rounded to the output fraction
    function longint unsigned arctan_deg(longint p, longint q);
      longint x, y, z, xs, ys;
      x = q <<< ppbd_pkg::PreShift;
      y = p <<< ppbd_pkg::PreShift;
      z = 0;
      for (int i = 0; i < ppbd_pkg::CordicSteps; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x += ys;
          y -= xs;
          z += ArctanLut[i];
        end else begin
          x -= ys;
          y += xs;
          z -= ArctanLut[i];
        end
      end
      if (z < 0) z = 0;
      return (z + (64'd1 << (ppbd_pkg::AngleShift - 1))) >> ppbd_pkg::AngleShift;
    endfunction

    function void note_pair(input logic signed [CoordW-1:0] fx, fy, sx, sy);
      bearing_rec_t    e;
      longint          dx, dy, p, q;
      longint unsigned sq, bear, full, half;
      full = longint'(ppbd_pkg::FullTurn);
      half = longint'(ppbd_pkg::HalfTurn);
      dx   = longint'(sx) - longint'(fx);
      dy   = longint'(sy) - longint'(fy);
      sq   = dx * dx + dy * dy;
      e.fx = fx;
      e.fy = fy;
      e.sx = sx;
      e.sy = sy;
      e.length = LengthW'((int_sqrt(sq << (2 * ppbd_pkg::FracBits + 2)) + 1) >> 1);
      bear = 0;
      if (dx == 0 && dy == 0) begin
        e.area   = ppbd_pkg::REGION_SAME;
        e.length = '0;
        e.bearing_out  = '0;
        e.bearing_back = '0;
      end else begin
        if (dx == 0) begin
          if (dy > 0) begin
            e.area = ppbd_pkg::REGION_UP;
            bear   = 0;
          end else begin
            e.area = ppbd_pkg::REGION_DOWN;
            bear   = half;
          end
        end else if (dy == 0) begin
          e.area = ppbd_pkg::REGION_HORIZ;
          bear   = (dx > 0) ? longint'(ppbd_pkg::QuarterTurn)
                            : longint'(ppbd_pkg::ThreeQTurn);
        end else begin
          if (dx > 0 && dy > 0) begin
            e.area = ppbd_pkg::REGION_NE; p = dx;  q = dy;
          end else if (dx > 0) begin
            e.area = ppbd_pkg::REGION_SE; p = -dy; q = dx;
          end else if (dy < 0) begin
            e.area = ppbd_pkg::REGION_SW; p = -dx; q = -dy;
          end else begin
            e.area = ppbd_pkg::REGION_NW; p = dy;  q = -dx;
          end
          bear = longint'(int'(e.area)) * longint'(ppbd_pkg::QuarterTurn)
                 + arctan_deg(p, q);
          bear = bear % full;
        end
        e.bearing_out  = BearingW'(bear);
        e.bearing_back = BearingW'((bear + half) % full);
      end
      awaited.push_back(e);
    endfunction

    function void check_result(input logic [LengthW-1:0] len,
                               input logic [BearingW-1:0] b_out, b_back,
                               input logic [RegionW-1:0] area);
      bearing_rec_t e;
      if (awaited.size() == 0) begin
        bad_count++;
        if (bad_count <= 10)
          $display("unexpected result: length %0d bearing %0d back %0d region %0d",
                   len, b_out, b_back, area);
        return;
      end
      e = awaited.pop_front();
      if (len !== e.length || b_out !== e.bearing_out ||
          b_back !== e.bearing_back || area !== e.area) begin
        bad_count++;
        if (bad_count <= 10) begin
          $display("mismatch for (%0d,%0d)->(%0d,%0d)", e.fx, e.fy, e.sx, e.sy);
          $display("  length  exp %0d got %0d", e.length, len);
          $display("  bearing exp %0d got %0d", e.bearing_out, b_out);
          $display("  back    exp %0d got %0d", e.bearing_back, b_back);
          $display("  region  exp %0d got %0d", int'(e.area), area);
        end
      end
    endfunction
  endclass

  logic                     clk_i      = 1'b0;
  logic                     rst_ni     = 1'b0;
  logic                     start      = 1'b0;
  logic                     busy;
  logic signed [CoordW-1:0] first_x_i  = '0;
  logic signed [CoordW-1:0] first_y_i  = '0;
  logic signed [CoordW-1:0] second_x_i = '0;
  logic signed [CoordW-1:0] second_y_i = '0;
  logic                     result_valid_o;
  logic [LengthW-1:0]       length_o;
  logic [BearingW-1:0]      bearing_out_o;
  logic [BearingW-1:0]      bearing_back_o;
  logic [RegionW-1:0]       region_o;

  bearing_scoreboard sb = new();
  bit                gaps_on = 1'b1;
  int unsigned       quiet_cycles = 0;

  point_pair_bearing_and_distance_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .first_x_i      (first_x_i),
    .first_y_i      (first_y_i),
    .second_x_i     (second_x_i),
    .second_y_i     (second_y_i),
    .result_valid_o (result_valid_o),
    .length_o       (length_o),
    .bearing_out_o  (bearing_out_o),
    .bearing_back_o (bearing_back_o),
    .region_o       (region_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // result side cannot stall, check every strobe
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o === 1'b1)
      sb.check_result(length_o, bearing_out_o, bearing_back_o, region_o);
  end

  // watchdog on cycles with neither an input nor a result transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && busy === 1'b0) || result_valid_o === 1'b1) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= StallLimit) begin
        $display("Some tests failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // random idle cycles with junk on the data lines, then one pair transfer
  task automatic send_pair(input int fx, fy, sx, sy);
    while (gaps_on && $urandom_range(0, 99) < 32) begin
      start      <= 1'b0;
      first_x_i  <= CoordW'($urandom);
      first_y_i  <= CoordW'($urandom);
      second_x_i <= CoordW'($urandom);
      second_y_i <= CoordW'($urandom);
      @(posedge clk_i);
    end
    start      <= 1'b1;
    first_x_i  <= CoordW'(fx);
    first_y_i  <= CoordW'(fy);
    second_x_i <= CoordW'(sx);
    second_y_i <= CoordW'(sy);
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_pair(CoordW'(fx), CoordW'(fy), CoordW'(sx), CoordW'(sy));
  endtask

  // mostly random pairs, with axis, coincident, near-axis and short cases
  task automatic send_random_pair();
    logic signed [CoordW-1:0] fx, fy, sx, sy;
    int unsigned kind;
    int          d;
    fx   = CoordW'($urandom);
    fy   = CoordW'($urandom);
    sx   = CoordW'($urandom);
    sy   = CoordW'($urandom);
    kind = $urandom_range(0, 99);
    d    = $urandom_range(0, 1) ? 1 : -1;
    if (kind < 10) begin
      sx = fx;
    end else if (kind < 20) begin
      sy = fy;
    end else if (kind < 25) begin
      sx = fx;
      sy = fy;
    end else if (kind < 40) begin
      sx = CoordW'(fx + int'($urandom_range(0, 16)) - 8);
      sy = CoordW'(fy + int'($urandom_range(0, 16)) - 8);
    end else if (kind < 48) begin
      sx = CoordW'(fx + d);
    end else if (kind < 55) begin
      sy = CoordW'(fy + d);
    end
    send_pair(int'(fx), int'(fy), int'(sx), int'(sy));
  endtask

  // stop sending until every result of the pairs in flight has arrived
  task automatic hold_until_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // coincident points, also at the corners of the range
    send_pair(0, 0, 0, 0);
    send_pair(-32768, 32767, -32768, 32767);
    // axis cases
    send_pair(0, 0, 0, 5);
    send_pair(0, 0, 0, -7);
    send_pair(3, 0, 10, 0);
    send_pair(10, -4, -20, -4);
    send_pair(0, 32767, 0, -32768);
    send_pair(0, -32768, 0, 32767);
    send_pair(-32768, 0, 32767, 0);
    send_pair(32767, 5, -32768, 5);
    // unit diagonals in every quadrant
    send_pair(0, 0, 1, 1);
    send_pair(0, 0, 1, -1);
    send_pair(0, 0, -1, -1);
    send_pair(0, 0, -1, 1);
    // full span diagonals, longest distance
    send_pair(-32768, -32768, 32767, 32767);
    send_pair(32767, 32767, -32768, -32768);
    send_pair(-32768, 32767, 32767, -32768);
    send_pair(32767, -32768, -32768, 32767);
    // angle next to an axis, negative angle clamp and wrap past 360
    send_pair(-32768, -32768, -32767, 32767);
    send_pair(-32768, -32768, 32767, -32767);
    send_pair(32767, -32768, 32766, 32767);
    send_pair(0, 0, 3, 4);
    send_pair(100, -200, -7, 13);
    hold_until_drained();

    for (int n = 0; n < RandomPairs; n++) begin
      // back to back stretch in the middle
      gaps_on = !(n >= 150 && n < 300);
      if (n == 320) hold_until_drained();
      send_random_pair();
    end

    start <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (ppbd_pkg::Latency + 8) @(posedge clk_i);
    if (sb.bad_count == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
